### sv/prlu_pkg.sv
// Shared types and constants of the per-source packet rate limiter.
// Used by every module of the block except prlu_fifo; depends on nothing.
package prlu_pkg;

   localparam int IP_W = 32;
   localparam int PORT_W = 16;
   localparam int LIMIT_W = 16;
   localparam int COUNT_W = 17;
   localparam int EXCESS_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [EXCESS_W-1:0] EXCESS_MAX = '1;

   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LIMIT_ENABLED = 2'd0,
      CSR_ADDRESS_LIMIT = 2'd1,
      CSR_PAIR_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_PASS,
      OP_TICK,
      OP_LOOKUP
   } op_type;

   typedef enum logic {
      TBL_IDLE,
      TBL_SCAN
   } tbl_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_WAIT,
      BACK_OUT
   } back_state_type;

   typedef struct packed {
      logic cmd;
      logic [IP_W-1:0] src_ip;
      logic [PORT_W-1:0] src_port;
   } req_type;

   typedef struct packed {
      logic limited;
      logic address_over;
      logic pair_over;
      logic table_full;
      logic [EXCESS_W-1:0] address_excess_total;
      logic [EXCESS_W-1:0] pair_excess_total;
   } rsp_type;

   typedef struct packed {
      logic enable;
      logic [LIMIT_W-1:0] address_limit;
      logic [LIMIT_W-1:0] pair_limit;
   } cfg_type;

   typedef struct packed {
      op_type op;
      logic address_on;
      logic pair_on;
      logic [IP_W-1:0] src_ip;
      logic [PORT_W-1:0] src_port;
   } job_type;

   typedef struct packed {
      logic busy;
      logic full;
      logic [COUNT_W-1:0] count;
   } tbl_status_type;

endpackage

### sv/prlu_fifo.sv
// Small register queue with push/full and pop/empty handshakes.
// Used between the front and back parts and at the result side; no dependencies.
module prlu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### sv/prlu_front.sv
// Front part: accepts requests, classifies them and queues them for the back part.
// Depends on prlu_pkg and prlu_fifo.
module prlu_front
   import prlu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   input  cfg_type cfg,
   input  logic    job_pop,
   output logic    job_empty,
   output job_type job
);

   job_type classified;

   always_comb begin
      classified.src_ip = req_data.src_ip;
      classified.src_port = req_data.src_port;
      classified.address_on = cfg.enable && (cfg.address_limit != '0);
      classified.pair_on = cfg.enable && (cfg.pair_limit != '0);
      if (req_data.cmd == CMD_TICK) begin
         classified.op = OP_TICK;
      end else if (classified.address_on || classified.pair_on) begin
         classified.op = OP_LOOKUP;
      end else begin
         classified.op = OP_PASS;
      end
   end

   prlu_fifo #(
      .WIDTH($bits(job_type)),
      .DEPTH(2)
   ) u_job_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .full   (full),
      .wr_data(classified),
      .pop    (job_pop),
      .empty  (job_empty),
      .rd_data(job)
   );

endmodule

### sv/prlu_tbl.sv
// One associative counter table: a key/count memory searched one entry per cycle.
// Entries fill from index zero, so a fill count stands in for valid bits. Depends on prlu_pkg.
module prlu_tbl
   import prlu_pkg::*;
#(
   parameter int ENTRIES = 64,
   parameter int KEY_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output tbl_status_type   status
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int FILL_W = $clog2(ENTRIES + 1);
   localparam int ROW_W = KEY_W + COUNT_W;

   logic [ROW_W-1:0] mem [ENTRIES];
   logic [ROW_W-1:0] rd_ff;

   tbl_state_type state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] ptr_ff, ptr_in;
   logic chk_v_ff, chk_v_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic full_ff, full_in;

   logic rd_en, wr_en, issue;
   logic [IDX_W-1:0] wr_idx;
   logic [ROW_W-1:0] wr_row;
   logic [KEY_W-1:0] rd_key;
   logic [COUNT_W-1:0] rd_count, bumped;

   assign rd_key = rd_ff[ROW_W-1:COUNT_W];
   assign rd_count = rd_ff[COUNT_W-1:0];
   assign bumped = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);
   assign issue = (ptr_ff < fill_ff);

   assign status.busy = (state_ff == TBL_SCAN);
   assign status.full = full_ff;
   assign status.count = count_ff;

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      ptr_in = ptr_ff;
      chk_v_in = chk_v_ff;
      chk_idx_in = chk_idx_ff;
      key_in = key_ff;
      count_in = count_ff;
      full_in = full_ff;
      rd_en = 1'b0;
      wr_en = 1'b0;
      wr_idx = chk_idx_ff;
      wr_row = {key_ff, bumped};
      unique case (state_ff)
         TBL_IDLE: begin
            if (start) begin
               key_in = key;
               ptr_in = '0;
               chk_v_in = 1'b0;
               state_in = TBL_SCAN;
            end
         end
         TBL_SCAN: begin
            chk_v_in = issue;
            if (issue) begin
               rd_en = 1'b1;
               chk_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in = ptr_ff + FILL_W'(1);
            end
            if (chk_v_ff && (rd_key == key_ff)) begin
               wr_en = 1'b1;
               count_in = bumped;
               full_in = 1'b0;
               state_in = TBL_IDLE;
            end else if (!chk_v_ff && !issue) begin
               if (fill_ff < FILL_W'(ENTRIES)) begin
                  wr_en = 1'b1;
                  wr_idx = fill_ff[IDX_W-1:0];
                  wr_row = {key_ff, COUNT_W'(1)};
                  fill_in = fill_ff + FILL_W'(1);
                  count_in = COUNT_W'(1);
                  full_in = 1'b0;
               end else begin
                  count_in = '0;
                  full_in = 1'b1;
               end
               state_in = TBL_IDLE;
            end
         end
      endcase
      if (clear) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TBL_IDLE;
         fill_ff <= '0;
         ptr_ff <= '0;
         chk_v_ff <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         ptr_ff <= ptr_in;
         chk_v_ff <= chk_v_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      key_ff <= key_in;
      count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_row;
      end
      if (rd_en) begin
         rd_ff <= mem[ptr_ff[IDX_W-1:0]];
      end
   end

endmodule

### sv/prlu_back.sv
// Back part: takes queued jobs, runs the enabled table searches and builds each result.
// Holds the excess counters. Depends on prlu_pkg.
module prlu_back
   import prlu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cfg_clear,
   input  cfg_type                  cfg,
   input  logic                     job_empty,
   output logic                     job_pop,
   input  job_type                  job,
   output logic                     tbl_clear,
   output logic                     address_start,
   output logic                     pair_start,
   output logic [IP_W-1:0]          address_key,
   output logic [IP_W+PORT_W-1:0]   pair_key,
   input  tbl_status_type           address_status,
   input  tbl_status_type           pair_status,
   input  logic                     out_full,
   output logic                     out_push,
   output rsp_type                  out_data
);

   back_state_type state_ff, state_in;
   job_type job_ff, job_in;
   rsp_type res_ff, res_in;
   logic [EXCESS_W-1:0] address_excess_ff, address_excess_in;
   logic [EXCESS_W-1:0] pair_excess_ff, pair_excess_in;
   logic address_over, pair_over;

   assign address_key = job.src_ip;
   assign pair_key = {job.src_ip, job.src_port};
   assign out_data = res_ff;

   assign address_over = job_ff.address_on && !address_status.full &&
                         (address_status.count > {1'b0, cfg.address_limit});
   assign pair_over = job_ff.pair_on && !pair_status.full &&
                      (pair_status.count > {1'b0, cfg.pair_limit});

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      res_in = res_ff;
      address_excess_in = address_excess_ff;
      pair_excess_in = pair_excess_ff;
      job_pop = 1'b0;
      tbl_clear = 1'b0;
      address_start = 1'b0;
      pair_start = 1'b0;
      out_push = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               job_in = job;
               res_in = '0;
               unique case (job.op)
                  OP_TICK: begin
                     tbl_clear = 1'b1;
                     address_excess_in = '0;
                     pair_excess_in = '0;
                     state_in = BACK_OUT;
                  end
                  OP_LOOKUP: begin
                     address_start = job.address_on;
                     pair_start = job.pair_on;
                     state_in = BACK_WAIT;
                  end
                  default: begin
                     res_in.address_excess_total = address_excess_ff;
                     res_in.pair_excess_total = pair_excess_ff;
                     state_in = BACK_OUT;
                  end
               endcase
            end
         end
         BACK_WAIT: begin
            if (!address_status.busy && !pair_status.busy) begin
               if (address_over && (address_excess_ff != EXCESS_MAX)) begin
                  address_excess_in = address_excess_ff + EXCESS_W'(1);
               end
               if (pair_over && (pair_excess_ff != EXCESS_MAX)) begin
                  pair_excess_in = pair_excess_ff + EXCESS_W'(1);
               end
               res_in.limited = address_over || pair_over;
               res_in.address_over = address_over;
               res_in.pair_over = pair_over;
               res_in.table_full = (job_ff.address_on && address_status.full) ||
                                   (job_ff.pair_on && pair_status.full);
               res_in.address_excess_total = address_excess_in;
               res_in.pair_excess_total = pair_excess_in;
               state_in = BACK_OUT;
            end
         end
         BACK_OUT: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
      if (cfg_clear) begin
         tbl_clear = 1'b1;
         address_excess_in = '0;
         pair_excess_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         address_excess_ff <= '0;
         pair_excess_ff <= '0;
      end else begin
         state_ff <= state_in;
         address_excess_ff <= address_excess_in;
         pair_excess_ff <= pair_excess_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      res_ff <= res_in;
   end

endmodule

### sv/per_source_packet_rate_limiter_unit.sv
// A tick or a pass-through request goes from the job queue by way of BACK_OUT into the result
// queue; a lookup first waits in BACK_WAIT for the table searches, which read one entry per
// cycle, so its time grows with the entries held by the larger table searched. The back part
// handles one request at a time and takes the next only after the last result is pushed.
// Reset is synchronous and empties both tables through their fill counts at once.
// Depends on prlu_pkg, prlu_front, prlu_tbl, prlu_back and prlu_fifo.
module per_source_packet_rate_limiter_unit
   import prlu_pkg::*;
#(
   parameter int ADDRESS_ENTRIES = 64,
   parameter int PAIR_ENTRIES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  req_type                req_data,
   output logic                   empty,
   input  logic                   pop,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic cfg_write, cfg_clear;
   logic job_empty, job_pop;
   job_type job;
   logic tbl_clear, address_start, pair_start;
   logic [IP_W-1:0] address_key;
   logic [IP_W+PORT_W-1:0] pair_key;
   tbl_status_type address_status, pair_status;
   logic out_full, out_push;
   rsp_type out_data;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;
   assign cfg_clear = cfg_write && (csr_index == CSR_LIMIT_ENABLED);

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (csr_index)
            CSR_LIMIT_ENABLED: cfg_in.enable = csr_wdata[0];
            CSR_ADDRESS_LIMIT: cfg_in.address_limit = csr_wdata[LIMIT_W-1:0];
            CSR_PAIR_LIMIT: cfg_in.pair_limit = csr_wdata[LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   prlu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .job_pop  (job_pop),
      .job_empty(job_empty),
      .job      (job)
   );

   prlu_tbl #(
      .ENTRIES(ADDRESS_ENTRIES),
      .KEY_W  (IP_W)
   ) u_address_tbl (
      .clock (clock),
      .reset (reset),
      .clear (tbl_clear),
      .start (address_start),
      .key   (address_key),
      .status(address_status)
   );

   prlu_tbl #(
      .ENTRIES(PAIR_ENTRIES),
      .KEY_W  (IP_W + PORT_W)
   ) u_pair_tbl (
      .clock (clock),
      .reset (reset),
      .clear (tbl_clear),
      .start (pair_start),
      .key   (pair_key),
      .status(pair_status)
   );

   prlu_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg_clear     (cfg_clear),
      .cfg           (cfg_ff),
      .job_empty     (job_empty),
      .job_pop       (job_pop),
      .job           (job),
      .tbl_clear     (tbl_clear),
      .address_start (address_start),
      .pair_start    (pair_start),
      .address_key   (address_key),
      .pair_key      (pair_key),
      .address_status(address_status),
      .pair_status   (pair_status),
      .out_full      (out_full),
      .out_push      (out_push),
      .out_data      (out_data)
   );

   prlu_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(2)
   ) u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (out_push),
      .full   (out_full),
      .wr_data(out_data),
      .pop    (pop),
      .empty  (empty),
      .rd_data(rsp_data)
   );

endmodule

### sv/prlu_checker.sv
// Port-level checks of the rate limiter and the bind that attaches them to the top level.
// Depends on prlu_pkg and per_source_packet_rate_limiter_unit.
module prlu_checker
   import prlu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input rsp_type rsp_data
);

   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_data.limited == (rsp_data.address_over || rsp_data.pair_over))
      else $error("limited flag disagrees with the over flags");

   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.address_over |-> rsp_data.address_excess_total != '0)
      else $error("address over without an address excess count");

   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.pair_over |-> rsp_data.pair_excess_total != '0)
      else $error("pair over without a pair excess count");

endmodule

bind per_source_packet_rate_limiter_unit prlu_checker u_prlu_checker (
   .clock   (clock),
   .reset   (reset),
   .full    (full),
   .empty   (empty),
   .rsp_data(rsp_data)
);

### tb/sv/tb_top.sv
// Self-checking testbench for per_source_packet_rate_limiter_unit: directed and random requests
// are checked against an internal prediction of the address and pair counting tables.
// Depends on prlu_pkg and the RTL of the rate limiter.
module tb_top;
   import prlu_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 7;
   localparam int ENTRIES = 64;
   localparam int KEY_W = IP_W + PORT_W;
   localparam int ADDRESS_TABLE = 0;
   localparam int PAIR_TABLE = 1;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_OFF_CYCLES = 500;
   localparam int TIMEOUT_CYCLES = 1200000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [IP_W-1:0] HOT_IP = 32'h0A00_0000;
   localparam logic [PORT_W-1:0] HOT_PORT = 16'd5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   req_type req_data = '0;
   logic empty;
   logic pop = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   req_type pending_requests[$];
   rsp_type expected_verdicts[$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_asked = 0;
   int hold_off_served = 0;
   int hold_off_left = 0;

   logic limit_on = 1'b0;
   logic [LIMIT_W-1:0] address_cap = '0;
   logic [LIMIT_W-1:0] pair_cap = '0;
   logic [KEY_W-1:0] flow_key [2][ENTRIES];
   bit flow_used [2][ENTRIES];
   int unsigned flow_count [2][ENTRIES];
   logic [EXCESS_W-1:0] address_excess_sum = '0;
   logic [EXCESS_W-1:0] pair_excess_sum = '0;

   per_source_packet_rate_limiter_unit #(
      .ADDRESS_ENTRIES(ENTRIES),
      .PAIR_ENTRIES(ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic void clear_flows();
      for (int t = 0; t < 2; t++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            flow_used[t][i] = 1'b0;
         end
      end
      address_excess_sum = '0;
      pair_excess_sum = '0;
   endfunction

   // Returns the new count of the key, or 0 when the key is new and no entry is free.
   function automatic int unsigned count_flow(int t, logic [KEY_W-1:0] key);
      int free_slot;
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (flow_used[t][i]) begin
            if (flow_key[t][i] == key) begin
               if (flow_count[t][i] < 32'(COUNT_MAX)) begin
                  flow_count[t][i]++;
               end
               return flow_count[t][i];
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (free_slot < 0) begin
         return 0;
      end
      flow_used[t][free_slot] = 1'b1;
      flow_key[t][free_slot] = key;
      flow_count[t][free_slot] = 1;
      return 1;
   endfunction

   function automatic rsp_type predict_verdict(req_type r);
      rsp_type v;
      int unsigned n;
      v = '0;
      if (r.cmd == CMD_TICK) begin
         clear_flows();
      end else if (limit_on) begin
         if (address_cap != 0) begin
            n = count_flow(ADDRESS_TABLE, KEY_W'(r.src_ip));
            if (n == 0) begin
               v.table_full = 1'b1;
            end else if (n > 32'(address_cap)) begin
               v.address_over = 1'b1;
               if (address_excess_sum != EXCESS_MAX) begin
                  address_excess_sum++;
               end
            end
         end
         if (pair_cap != 0) begin
            n = count_flow(PAIR_TABLE, {r.src_ip, r.src_port});
            if (n == 0) begin
               v.table_full = 1'b1;
            end else if (n > 32'(pair_cap)) begin
               v.pair_over = 1'b1;
               if (pair_excess_sum != EXCESS_MAX) begin
                  pair_excess_sum++;
               end
            end
         end
      end
      v.limited = v.address_over | v.pair_over;
      v.address_excess_total = address_excess_sum;
      v.pair_excess_total = pair_excess_sum;
      return v;
   endfunction

   task automatic compare_field(string name, logic [EXCESS_W-1:0] want, logic [EXCESS_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_verdict(rsp_type got);
      rsp_type want;
      want = expected_verdicts.pop_front();
      compare_field("limited", EXCESS_W'(want.limited), EXCESS_W'(got.limited));
      compare_field("address_over", EXCESS_W'(want.address_over), EXCESS_W'(got.address_over));
      compare_field("pair_over", EXCESS_W'(want.pair_over), EXCESS_W'(got.pair_over));
      compare_field("table_full", EXCESS_W'(want.table_full), EXCESS_W'(got.table_full));
      compare_field("address_excess_total", want.address_excess_total,
                    got.address_excess_total);
      compare_field("pair_excess_total", want.pair_excess_total, got.pair_excess_total);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!(push && full)) begin
         if (push) begin
            expected_verdicts.push_back(predict_verdict(req_data));
         end
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_requests.pop_front();
            push <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_verdicts.size() == 0) begin
               $error("result with no request outstanding");
               mismatch_count++;
            end else begin
               check_verdict(rsp_data);
            end
         end
         if (hold_off_served != hold_off_asked) begin
            hold_off_served <= hold_off_asked;
            hold_off_left <= HOLD_OFF_CYCLES;
            pop <= 1'b0;
         end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LIMIT_ENABLED: begin
            limit_on = value[0];
            clear_flows();
         end
         CSR_ADDRESS_LIMIT: begin
            address_cap = value;
         end
         CSR_PAIR_LIMIT: begin
            pair_cap = value;
         end
         default: begin
         end
      endcase
   endtask

   task automatic configure(logic enable, logic [LIMIT_W-1:0] a_limit,
                            logic [LIMIT_W-1:0] p_limit);
      write_csr(CSR_ADDRESS_LIMIT, a_limit);
      write_csr(CSR_PAIR_LIMIT, p_limit);
      write_csr(CSR_LIMIT_ENABLED, CSR_DATA_W'(enable));
   endtask

   task automatic queue_request(logic cmd, logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
      req_type r;
      r.cmd = cmd;
      r.src_ip = ip;
      r.src_port = port;
      pending_requests.push_back(r);
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_requests.size() != 0 || push || expected_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Packets come from a few hot sources so that counters climb past their limits, or, at
   // fresh_pct percent, from fresh sources that fill the tables.
   task automatic random_segment(int count, int tick_per_mille, int fresh_pct);
      req_type r;
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         r.cmd = ($urandom_range(999) < tick_per_mille) ? CMD_TICK : CMD_PACKET;
         if ($urandom_range(99) < fresh_pct) begin
            r.src_ip = $urandom;
            r.src_port = PORT_W'($urandom);
         end else begin
            r.src_ip = HOT_IP | IP_W'($urandom_range(3));
            r.src_port = HOT_PORT + PORT_W'($urandom_range(3));
         end
         pending_requests.push_back(r);
      end
      wait_drained();
   endtask

   initial begin
      send_idle_pct = 24;
      recv_idle_pct = 67;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Limiting is off after reset, so these pass untouched.
      @(negedge clock);
      queue_request(CMD_PACKET, '0, '0);
      queue_request(CMD_PACKET, '1, '1);
      queue_request(CMD_TICK, '1, '0);
      wait_drained();

      configure(1'b1, 16'd1, 16'd2);
      @(negedge clock);
      queue_request(CMD_PACKET, HOT_IP, HOT_PORT);
      queue_request(CMD_PACKET, HOT_IP, HOT_PORT);
      queue_request(CMD_PACKET, HOT_IP, HOT_PORT + 16'd1);
      queue_request(CMD_PACKET, HOT_IP, HOT_PORT);
      queue_request(CMD_PACKET, HOT_IP + 32'd1, HOT_PORT);
      queue_request(CMD_TICK, HOT_IP, HOT_PORT);
      queue_request(CMD_PACKET, HOT_IP, HOT_PORT);
      queue_request(CMD_PACKET, HOT_IP, HOT_PORT);
      wait_drained();

      // Rewriting the enable clears the counts just like a tick.
      write_csr(CSR_LIMIT_ENABLED, 16'd1);
      @(negedge clock);
      queue_request(CMD_PACKET, HOT_IP, HOT_PORT);
      queue_request(CMD_PACKET, '1, '0);
      queue_request(CMD_PACKET, '0, '1);
      wait_drained();

      write_csr(CSR_UNUSED_INDEX, 16'hFFFF);
      write_csr(CSR_LIMIT_ENABLED, 16'hFFFE);
      @(negedge clock);
      queue_request(CMD_PACKET, HOT_IP, HOT_PORT);
      queue_request(CMD_TICK, '0, '0);
      wait_drained();

      configure(1'b1, 16'd2, 16'd3);
      random_segment(250, 30, 20);
      configure(1'b1, 16'hFFFF, 16'd1);
      random_segment(300, 3, 40);
      configure(1'b1, 16'd0, 16'd2);
      random_segment(200, 20, 25);

      @(negedge clock);
      send_idle_pct = 67;
      recv_idle_pct = 24;
      configure(1'b1, 16'd5, 16'd0);
      random_segment(250, 2, 50);
      configure(1'b1, 16'd1, 16'hFFFF);
      random_segment(250, 10, 30);

      @(negedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(1'b0, 16'd3, 16'd3);
      @(negedge clock);
      hold_off_asked++;
      random_segment(300, 20, 30);
      configure(1'b1, LIMIT_W'($urandom_range(1, 8)), LIMIT_W'($urandom_range(1, 8)));
      random_segment(350, 15, 25);
      configure(1'b1, 16'd0, 16'd0);
      random_segment(100, 20, 50);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("status: fail");
      $finish;
   end

endmodule

### filelist.f
sv/prlu_pkg.sv
sv/prlu_fifo.sv
sv/prlu_front.sv
sv/prlu_tbl.sv
sv/prlu_back.sv
sv/per_source_packet_rate_limiter_unit.sv
sv/prlu_checker.sv
tb/sv/tb_top.sv
